// ===== sv/dtf_pkg.sv =====
// Shared constants and types for the decimal thousands formatter.
`default_nettype none
package dtf_pkg;
	localparam int VALUE_WIDTH = 64;
	// enough BCD digits for magnitudes up to 2^(VALUE_WIDTH-1)
	localparam int NUM_DIGITS  = 19;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);
	localparam int REM_W       = $clog2(NUM_DIGITS + 1);
	localparam int GROUP_SIZE  = 3;
	localparam logic [1:0] GRP_INIT = 2'(NUM_DIGITS % GROUP_SIZE);
	localparam logic [1:0] GRP_SEP  = 2'd1;
	localparam logic [1:0] GRP_TOP  = 2'(GROUP_SIZE - 1);

	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_NINE   = 8'd57;
	localparam logic [7:0] CH_MINUS  = 8'd45;
	localparam logic [7:0] SEP_RESET = 8'd44;

	typedef logic [3:0] bcd_t;

	// per-cycle command to every digit cell
	typedef struct packed {
		logic clr;   // zero the digit
		logic conv;  // add-3 and shift left, taking the carry from below
		logic shift; // take the digit of the lower neighbor
	} cell_ctrl_t;
endpackage
`default_nettype wire

// ===== sv/dtf_cell.sv =====
// One BCD digit cell of the binary-to-decimal chain.
`default_nettype none
module dtf_cell (
	input  wire                    clk,
	input  wire                    arst_n,
	input  dtf_pkg::cell_ctrl_t    ctrl,
	input  wire                    cin,
	input  dtf_pkg::bcd_t          din,
	output logic                   cout,
	output dtf_pkg::bcd_t          dout
);
	import dtf_pkg::*;

	bcd_t digit_q;
	bcd_t adj;

	// double dabble: correct digits of 5 and up before the shift
	assign adj  = (digit_q >= 4'd5) ? bcd_t'(digit_q + 4'd3) : digit_q;
	assign cout = adj[3];
	assign dout = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctrl.clr) begin
			digit_q <= '0;
		end else if (ctrl.conv) begin
			digit_q <= {adj[2:0], cin};
		end else if (ctrl.shift) begin
			digit_q <= din;
		end
	end
endmodule
`default_nettype wire

// ===== sv/decimal_thousands_formatter_top.sv =====
// Top level: signed integer to decimal ASCII text with group separators.
//
//  channel  | dir | signals                           | payload
//  s_axis   | in  | s_axis_tvalid/tready/tdata        | tdata[63:0] value
//  m_axis   | out | m_axis_tvalid/tready/tdata/tlast  | tdata[7:0] char_code, tlast last_char
//  cfg      | in  | cfg_we, cfg_wdata                 | separator_char
//
// One number at a time. After the request, the 19-cell BCD chain shifts in one
// magnitude bit per cycle, then leading zeros are dropped (up to 18), then the
// characters go out one per cycle while the output is not stalled (up to 26, for
// the most negative value).
// Reset clears control state and sets the separator to a comma.
// A stalled output holds the character and stops the emitter; the next number
// is taken as soon as the last character sits in the output register.
`default_nettype none
module decimal_thousands_formatter_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [63:0] s_axis_tdata,  // [63:0] value
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] char_code
	output logic        m_axis_tlast,  // last_char
	input  wire         cfg_we,
	input  wire  [7:0]  cfg_wdata
);
	import dtf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_MINUS,
		ST_DIGIT,
		ST_SEP
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [REM_W-1:0]       rem_q;
	logic [1:0]             grp_q;
	logic [7:0]             sep_q;
	logic                   out_valid_q;
	logic [7:0]             out_char_q;
	logic                   out_last_q;

	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] neg_raw;
	logic                   in_req;
	logic                   adv;
	logic                   drop;
	logic                   top_zero;
	logic [1:0]             grp_dec;
	cell_ctrl_t             ctrl;
	logic [NUM_DIGITS:0]    carry;
	bcd_t                   dig [NUM_DIGITS];
	bcd_t                   top;

	assign raw     = s_axis_tdata[VALUE_WIDTH-1:0];
	assign neg_raw = VALUE_WIDTH'(~raw + 1'b1);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_req        = s_axis_tvalid && s_axis_tready;
	assign adv           = !out_valid_q || m_axis_tready;
	assign top           = dig[NUM_DIGITS-1];
	assign top_zero      = (top == 4'd0);
	assign drop          = top_zero && (rem_q != REM_W'(1));
	assign grp_dec       = (grp_q == 2'd0) ? GRP_TOP : 2'(grp_q - 2'd1);

	always_comb begin
		ctrl.clr   = in_req;
		ctrl.conv  = (state_q == ST_CONV);
		ctrl.shift = ((state_q == ST_SKIP) && drop) || ((state_q == ST_DIGIT) && adv);
	end

	assign carry[0] = mag_q[VALUE_WIDTH-1];

	genvar i;
	generate
		for (i = 0; i < NUM_DIGITS; i++) begin : g_cell
			bcd_t nb;
			if (i == 0) begin : g_low
				assign nb = '0;
			end else begin : g_up
				assign nb = dig[i-1];
			end
			dtf_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctrl  (ctrl),
				.cin   (carry[i]),
				.din   (nb),
				.cout  (carry[i+1]),
				.dout  (dig[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sep_q       <= SEP_RESET;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			cnt_q       <= '0;
			rem_q       <= '0;
			grp_q       <= '0;
			neg_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				sep_q <= cfg_wdata;
			end
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_req) begin
						neg_q   <= raw[VALUE_WIDTH-1];
						mag_q   <= raw[VALUE_WIDTH-1] ? neg_raw : raw;
						cnt_q   <= CNT_W'(VALUE_WIDTH - 1);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
					cnt_q <= CNT_W'(cnt_q - 1'b1);
					if (cnt_q == '0) begin
						rem_q   <= REM_W'(NUM_DIGITS);
						grp_q   <= GRP_INIT;
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (drop) begin
						rem_q <= REM_W'(rem_q - 1'b1);
						grp_q <= grp_dec;
					end else begin
						state_q <= neg_q ? ST_MINUS : ST_DIGIT;
					end
				end
				ST_MINUS: begin
					if (adv) begin
						out_valid_q <= 1'b1;
						out_char_q  <= CH_MINUS;
						out_last_q  <= 1'b0;
						state_q     <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (adv) begin
						out_valid_q <= 1'b1;
						out_char_q  <= CH_ZERO + {4'd0, top};
						out_last_q  <= (rem_q == REM_W'(1));
						rem_q       <= REM_W'(rem_q - 1'b1);
						grp_q       <= grp_dec;
						if (rem_q == REM_W'(1)) begin
							state_q <= ST_IDLE;
						end else if (grp_q == GRP_SEP) begin
							state_q <= ST_SEP;
						end
					end
				end
				ST_SEP: begin
					if (adv) begin
						out_valid_q <= 1'b1;
						out_char_q  <= sep_q;
						out_last_q  <= 1'b0;
						state_q     <= ST_DIGIT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;
endmodule
`default_nettype wire

// ===== sv/dtf_checker.sv =====
// Port-level checks for the decimal thousands formatter, bound to the top level.
`default_nettype none
module dtf_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [7:0]  m_axis_tdata,
	input wire        m_axis_tlast
);
	import dtf_pkg::*;

	// a request starts a multi-cycle conversion: no second request right after
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after a request");

	// conversion takes many cycles before the first character can appear
	a_no_early_char: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 !m_axis_tvalid)
		else $error("character produced too soon after a request");

	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata >= CH_ZERO && m_axis_tdata <= CH_NINE)
		else $error("final character is not a digit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled output changed");
endmodule

bind decimal_thousands_formatter_top dtf_checker u_dtf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);
`default_nettype wire

// ===== verif/decimal_thousands_formatter_top_test.sv =====
// Testbench for decimal_thousands_formatter_top: integer-to-text stream, checked per character.
module decimal_thousands_formatter_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dtf_pkg::*;

	localparam int          CYCLE_LIMIT   = 2_000_000;
	localparam int          DRAIN_CYCLES  = 8;
	localparam int          RANDOM_VALUES = 340;
	localparam int          STEADY_VALUES = 60;
	localparam logic [63:0] DIGIT_BASE    = 64'd10;
	localparam logic [63:0] INT_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT_MIN       = 64'h8000_0000_0000_0000;

	typedef struct {
		logic [7:0] char_code;
		logic       last_char;
	} text_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	text_char_t  pending_text[$];
	logic [7:0]  sep_setting = SEP_RESET;
	bit          src_idle_en = 1'b0;
	bit          sink_idle_en = 1'b0;
	int          sink_hold = 0;
	int          cycle_count = 0;
	int          mismatch_count = 0;
	int          numbers_sent = 0;
	int          chars_checked = 0;
	int          sep_writes = 0;

	decimal_thousands_formatter_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d characters outstanding",
				cycle_count, pending_text.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// output backpressure: random stall bursts
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
			sink_hold <= $urandom_range(0, 15);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			chars_checked <= chars_checked + 1;
			if (pending_text.size() == 0) begin
				$error("char_code: expected none, actual 0x%02h (tlast %0b)",
					m_axis_tdata, m_axis_tlast);
				mismatch_count++;
			end else begin
				want = pending_text.pop_front();
				if (m_axis_tdata !== want.char_code) begin
					$error("char_code: expected 0x%02h, actual 0x%02h",
						want.char_code, m_axis_tdata);
					mismatch_count++;
				end
				if (m_axis_tlast !== want.last_char) begin
					$error("last_char: expected %0b, actual %0b",
						want.last_char, m_axis_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// expected text of one number, most significant character first
	function automatic void format_decimal(input logic [63:0] value);
		text_char_t text[$];
		logic [63:0] mag;
		logic        neg;
		int          group;
		neg   = value[63];
		mag   = neg ? -value : value;
		group = 0;
		do begin
			if (group == GROUP_SIZE) begin
				text.push_front('{char_code: sep_setting, last_char: 1'b0});
				group = 0;
			end
			text.push_front('{char_code: CH_ZERO + 8'(mag % DIGIT_BASE), last_char: 1'b0});
			mag = mag / DIGIT_BASE;
			group++;
		end while (mag != 0);
		if (neg)
			text.push_front('{char_code: CH_MINUS, last_char: 1'b0});
		text[text.size() - 1].last_char = 1'b1;
		foreach (text[i])
			pending_text.push_back(text[i]);
	endfunction

	task automatic send_value(input logic [63:0] value);
		if (src_idle_en && $urandom_range(0, 2) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		format_decimal(value);
		numbers_sent++;
	endtask

	// called right after the last request; holds valid low until all text is back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_separator(input logic [7:0] sep);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= sep;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sep_setting = sep;
		sep_writes++;
	endtask

	function automatic logic [63:0] random_value();
		logic [63:0] v;
		int          k;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: ;
			1: v = v & ((64'd1 << $urandom_range(1, 63)) - 64'd1);
			2: v = -(v & ((64'd1 << $urandom_range(1, 63)) - 64'd1));
			3: begin
				// around a power of ten, where digit and group counts change
				k = $urandom_range(0, 18);
				v = 64'd1;
				repeat (k) v = v * DIGIT_BASE;
				v = v + 64'($urandom_range(0, 2)) - 64'd1;
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
			4: v = 64'($urandom_range(0, 4000)) - 64'd2000;
			default: v = ($urandom_range(0, 1) == 1) ? INT_MAX - 64'($urandom_range(0, 3))
				: INT_MIN + 64'($urandom_range(0, 3));
		endcase
		return v;
	endfunction

	// default comma separator right after reset; edges of digit and group counts
	task automatic test_default_separator();
		logic [63:0] values[$];
		values = '{64'd0, 64'd1, -64'd1, 64'd9, -64'd9, 64'd10, 64'd99, 64'd100, 64'd999,
			64'd1000, -64'd1000, 64'd999_999, 64'd1_000_000, -64'd123_456_789,
			64'd999_999_999_999_999_999, 64'd1_000_000_000_000_000_000,
			INT_MAX, -INT_MAX, INT_MIN, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};
		foreach (values[i])
			send_value(values[i]);
		wait_drained();
	endtask

	// separator extremes; the most negative value shows all six separators
	task automatic test_separator_codes();
		logic [7:0] seps[$];
		seps = '{8'h00, 8'hFF, 8'h2E, 8'(SEP_RESET), 8'($urandom_range(0, 255))};
		foreach (seps[i]) begin
			write_separator(seps[i]);
			send_value(INT_MIN);
		end
		wait_drained();
	endtask

	task automatic test_random_values();
		for (int n = 0; n < RANDOM_VALUES; n++) begin
			if (n % 40 == 0) begin
				src_idle_en  = ($urandom_range(0, 3) != 0);
				sink_idle_en = ($urandom_range(0, 3) != 0);
			end
			// mid-run: hold off until empty and pick a new separator
			if (n % 85 == 84)
				write_separator(8'($urandom_range(0, 255)));
			send_value(random_value());
		end
		wait_drained();
	endtask

	task automatic test_steady_stream();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		write_separator(8'(SEP_RESET));
		for (int n = 0; n < STEADY_VALUES; n++)
			send_value(random_value());
		wait_drained();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_separator();
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		test_separator_codes();
		test_random_values();
		test_steady_stream();
		$display("Formatted %0d numbers into %0d characters across %0d separator settings,",
			numbers_sent, chars_checked, sep_writes + 1);
		$display("including both extremes, decimal boundaries and random stalls on both sides.");
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
